FILE: sv/turing_machine_stepper_top_defines.svh
// ----------------------------------------------------------------------------
// Turing machine stepper assertion macros
// Shared forms for the concurrent checks on the stepper's ports.
// ----------------------------------------------------------------------------
`ifndef TURING_MACHINE_STEPPER_TOP_DEFINES_SVH
`define TURING_MACHINE_STEPPER_TOP_DEFINES_SVH

// A property that must hold on every clock edge outside reset.
`define TMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition that must never be seen on a clock edge outside reset.
`define TMS_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

FILE: sv/tms_pkg.sv
// ----------------------------------------------------------------------------
// Turing machine stepper package
// Types, codes and reset constants shared by the stepper's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tms_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HALT_STATE  = 2'd2;

	localparam logic [6:0] START_STATE_RESET = 7'd0;
	localparam logic [5:0] START_HEAD_RESET  = 6'd1;
	localparam logic [6:0] HALT_STATE_RESET  = 7'd104;

	localparam logic [2:0] ACT_LOAD    = 3'd0;
	localparam logic [2:0] ACT_WRITE   = 3'd1;
	localparam logic [2:0] ACT_READ    = 3'd2;
	localparam logic [2:0] ACT_RESTART = 3'd3;
	localparam logic [2:0] ACT_STEP    = 3'd4;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_NORULE = 2'd1;
	localparam logic [1:0] STATUS_BOUNDS = 2'd2;
	localparam logic [1:0] STATUS_HALTED = 2'd3;

	localparam logic [1:0] MOVE_STAY  = 2'b00;
	localparam logic [1:0] MOVE_RIGHT = 2'b01;
	localparam logic [1:0] MOVE_BAD   = 2'b10;
	localparam logic [1:0] MOVE_LEFT  = 2'b11;

	// One rule memory entry; an all-zero entry is an empty rule.
	typedef struct packed {
		logic       valid;
		logic       wr;
		logic [6:0] nxt;
		logic [1:0] move;
	} rule_t;

	// One result item.
	typedef struct packed {
		logic [6:0]  machine_state;
		logic [5:0]  head_cell;
		logic        symbol_out;
		logic        halted;
		logic [1:0]  status;
		logic [31:0] steps_done;
	} res_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_CELL  = 5'b00100,
		ST_RULE  = 5'b01000,
		ST_HEAD  = 5'b10000
	} fsm_t;

endpackage

`default_nettype wire

FILE: sv/tms_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/tms_core.sv
// ----------------------------------------------------------------------------
// Turing machine stepper control
// Sequencer, machine registers and memory access generation.
// ----------------------------------------------------------------------------
`default_nettype none

module tms_core #(
	parameter int TAPE_CELLS  = 64,
	parameter int STATE_COUNT = 128
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	output logic                                      done,
	input  wire logic [2:0]                           action,
	input  wire logic [6:0]                           rule_state,
	input  wire logic                                 rule_symbol,
	input  wire logic                                 rule_write,
	input  wire logic [6:0]                           rule_next,
	input  wire logic signed [1:0]                    rule_move,
	input  wire logic [5:0]                           cell_index,
	input  wire logic                                 cell_symbol,
	input  wire logic                                 cfg_we,
	input  wire logic [tms_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [tms_pkg::CFG_DATA_W-1:0]       cfg_data,
	output logic                                      rule_we,
	output logic [$clog2(2*STATE_COUNT)-1:0]          rule_waddr,
	output tms_pkg::rule_t                            rule_wdata,
	output logic                                      rule_re,
	output logic [$clog2(2*STATE_COUNT)-1:0]          rule_raddr,
	input  wire tms_pkg::rule_t                       rule_rdata,
	output logic                                      tape_we,
	output logic [$clog2(TAPE_CELLS)-1:0]             tape_waddr,
	output logic                                      tape_wdata,
	output logic                                      tape_re,
	output logic [$clog2(TAPE_CELLS)-1:0]             tape_raddr,
	input  wire logic                                 tape_rdata,
	output tms_pkg::res_t                             res
);

	import tms_pkg::*;

	localparam int TW        = $clog2(TAPE_CELLS);
	localparam int AW        = $clog2(2 * STATE_COUNT);
	localparam int CLR_DEPTH = (2 * STATE_COUNT > TAPE_CELLS) ? 2 * STATE_COUNT : TAPE_CELLS;
	localparam int CW        = $clog2(CLR_DEPTH);

	fsm_t          state_q, state_d;
	logic [CW-1:0] clr_q;
	logic [6:0]    mstate_q, mstate_d;
	logic [TW-1:0] head_q, head_d;
	logic          halted_q, halted_d;
	logic [31:0]   steps_q, steps_d;
	logic          hsym_q, hsym_d;
	logic [6:0]    start_state_q;
	logic [5:0]    start_head_q;
	logic [6:0]    halt_state_q;
	logic          done_q;
	res_t          res_q;
	logic          cell_ok_q;
	logic          fwd_q, fwd_d;
	logic          fwd_sym_q;

	logic          accept;
	logic          cell_ok;
	logic          load_ok;
	logic [TW-1:0] start_head_clamp;
	logic [TW-1:0] nh;
	logic          fin;
	logic [1:0]    fin_status;
	logic          use_read;
	logic          fin_sym;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && (state_q == ST_IDLE);
	assign cell_ok = (32'(cell_index) < 32'(TAPE_CELLS));
	assign load_ok = (32'(rule_state) < 32'(STATE_COUNT));
	assign start_head_clamp = (32'(start_head_q) < 32'(TAPE_CELLS)) ?
		TW'(start_head_q) : TW'(TAPE_CELLS - 1);

	// Head after the move of the rule just read.
	always_comb begin
		unique case (rule_rdata.move)
			MOVE_RIGHT: nh = head_q + TW'(1);
			MOVE_LEFT:  nh = head_q - TW'(1);
			default:    nh = head_q;
		endcase
	end

	always_comb begin
		state_d    = state_q;
		mstate_d   = mstate_q;
		head_d     = head_q;
		halted_d   = halted_q;
		steps_d    = steps_q;
		hsym_d     = hsym_q;
		fwd_d      = 1'b0;
		fin        = 1'b0;
		fin_status = STATUS_OK;
		use_read   = 1'b0;
		rule_we    = 1'b0;
		rule_waddr = '0;
		rule_wdata = '0;
		rule_re    = 1'b0;
		rule_raddr = AW'({mstate_q, hsym_q});
		tape_we    = 1'b0;
		tape_waddr = head_q;
		tape_wdata = 1'b0;
		tape_re    = 1'b0;
		tape_raddr = TW'(cell_index);

		unique case (state_q)
			ST_CLEAR: begin
				rule_we    = 1'b1;
				rule_waddr = AW'(clr_q);
				tape_we    = 1'b1;
				tape_waddr = TW'(clr_q);
				if (clr_q == CW'(CLR_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (action)
						ACT_LOAD: begin
							rule_we          = load_ok;
							rule_waddr       = AW'({rule_state, rule_symbol});
							rule_wdata.valid = 1'b1;
							rule_wdata.wr    = rule_write;
							rule_wdata.nxt   = rule_next;
							rule_wdata.move  = (rule_move == MOVE_BAD) ? MOVE_STAY : rule_move;
							fin              = 1'b1;
						end
						ACT_WRITE: begin
							tape_we    = cell_ok;
							tape_waddr = TW'(cell_index);
							tape_wdata = cell_symbol;
							if (cell_ok && TW'(cell_index) == head_q) begin
								hsym_d = cell_symbol;
							end
							fin = 1'b1;
						end
						ACT_READ: begin
							tape_re = 1'b1;
							state_d = ST_CELL;
						end
						ACT_RESTART: begin
							mstate_d   = start_state_q;
							head_d     = start_head_clamp;
							halted_d   = (start_state_q == halt_state_q);
							steps_d    = '0;
							tape_re    = 1'b1;
							tape_raddr = start_head_clamp;
							state_d    = ST_HEAD;
						end
						ACT_STEP: begin
							priority if (halted_q) begin
								fin        = 1'b1;
								fin_status = STATUS_HALTED;
							end else if (32'(mstate_q) >= 32'(STATE_COUNT)) begin
								fin        = 1'b1;
								fin_status = STATUS_NORULE;
							end else begin
								rule_re = 1'b1;
								state_d = ST_RULE;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			ST_CELL: begin
				fin      = 1'b1;
				use_read = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_RULE: begin
				priority if (!rule_rdata.valid) begin
					fin        = 1'b1;
					fin_status = STATUS_NORULE;
					state_d    = ST_IDLE;
				end else if ((rule_rdata.move == MOVE_RIGHT && head_q == TW'(TAPE_CELLS - 1)) ||
					(rule_rdata.move == MOVE_LEFT && head_q == '0)) begin
					fin        = 1'b1;
					fin_status = STATUS_BOUNDS;
					state_d    = ST_IDLE;
				end else begin
					tape_we    = 1'b1;
					tape_waddr = head_q;
					tape_wdata = rule_rdata.wr;
					tape_re    = 1'b1;
					tape_raddr = nh;
					fwd_d      = (nh == head_q);
					head_d     = nh;
					mstate_d   = rule_rdata.nxt;
					halted_d   = (rule_rdata.nxt == halt_state_q);
					steps_d    = (steps_q == '1) ? steps_q : steps_q + 32'd1;
					state_d    = ST_HEAD;
				end
			end
			ST_HEAD: begin
				hsym_d  = fwd_q ? fwd_sym_q : tape_rdata;
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign fin_sym = use_read ? (cell_ok_q & tape_rdata) : hsym_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			mstate_q      <= '0;
			head_q        <= TW'(1);
			halted_q      <= 1'b0;
			steps_q       <= '0;
			hsym_q        <= 1'b0;
			done_q        <= 1'b0;
			start_state_q <= START_STATE_RESET;
			start_head_q  <= START_HEAD_RESET;
			halt_state_q  <= HALT_STATE_RESET;
		end else begin
			state_q  <= state_d;
			mstate_q <= mstate_d;
			head_q   <= head_d;
			halted_q <= halted_d;
			steps_q  <= steps_d;
			hsym_q   <= hsym_d;
			done_q   <= fin;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_STATE: start_state_q <= cfg_data;
					CFG_START_HEAD:  start_head_q  <= cfg_data[5:0];
					CFG_HALT_STATE:  halt_state_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_q     <= fwd_d;
		fwd_sym_q <= rule_rdata.wr;
		if (accept) begin
			cell_ok_q <= cell_ok;
		end
		if (fin) begin
			res_q.machine_state <= mstate_d;
			res_q.head_cell     <= 6'(head_d);
			res_q.symbol_out    <= fin_sym;
			res_q.halted        <= halted_d;
			res_q.status        <= fin_status;
			res_q.steps_done    <= steps_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

`default_nettype wire

FILE: sv/turing_machine_stepper_top.sv
// ----------------------------------------------------------------------------
// Turing machine stepper
// Single-tape, two-symbol Turing machine with a loadable rule memory.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and the receiver
// cannot hold it off, so capture it in that cycle. Loading a rule, writing a
// cell, an unknown action and a step refused up front (machine halted, or
// current state beyond the rule memory) answer in the cycle after the item is
// taken, and busy stays low so the next item can be taken in that same cycle.
// Reading a cell and a restart pass through one more state, ST_CELL or
// ST_HEAD, since each waits for one registered read of the tape memory. A
// step reads the rule memory at the current state and head symbol, then in
// ST_RULE writes the tape under the head while reading the cell under the
// new head, and in ST_HEAD picks up that symbol; a step refused by its rule
// (no valid rule, or a move off the tape) answers from ST_RULE. After reset,
// busy stays high while both memories are swept clear one entry a cycle,
// max(2*STATE_COUNT, TAPE_CELLS) entries, 256 with the default sizes. The
// three configuration registers are written through cfg_we, cfg_index and
// cfg_data at any edge and are meant to change only while the block is idle;
// an index beyond the list is ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module turing_machine_stepper_top #(
	parameter int TAPE_CELLS  = 64,
	parameter int STATE_COUNT = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	input  wire logic [2:0]        action,
	input  wire logic [6:0]        rule_state,
	input  wire logic              rule_symbol,
	input  wire logic              rule_write,
	input  wire logic [6:0]        rule_next,
	input  wire logic signed [1:0] rule_move,
	input  wire logic [5:0]        cell_index,
	input  wire logic              cell_symbol,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [6:0]        cfg_data,
	output logic [6:0]             machine_state,
	output logic [5:0]             head_cell,
	output logic                   symbol_out,
	output logic                   halted,
	output logic [1:0]             status,
	output logic [31:0]            steps_done
);

	import tms_pkg::*;

	localparam int TW = $clog2(TAPE_CELLS);
	localparam int AW = $clog2(2 * STATE_COUNT);

	// Rule memory: one entry per (state, read symbol), valid bit on top.
	logic          rule_we;
	logic [AW-1:0] rule_waddr;
	rule_t         rule_wdata;
	logic          rule_re;
	logic [AW-1:0] rule_raddr;
	rule_t         rule_rdata;

	// Tape memory: one bit per cell.
	logic          tape_we;
	logic [TW-1:0] tape_waddr;
	logic          tape_wdata;
	logic          tape_re;
	logic [TW-1:0] tape_raddr;
	logic          tape_rdata;

	res_t          res;

	tms_core #(
		.TAPE_CELLS  (TAPE_CELLS),
		.STATE_COUNT (STATE_COUNT)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.done        (done),
		.action      (action),
		.rule_state  (rule_state),
		.rule_symbol (rule_symbol),
		.rule_write  (rule_write),
		.rule_next   (rule_next),
		.rule_move   (rule_move),
		.cell_index  (cell_index),
		.cell_symbol (cell_symbol),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rule_we     (rule_we),
		.rule_waddr  (rule_waddr),
		.rule_wdata  (rule_wdata),
		.rule_re     (rule_re),
		.rule_raddr  (rule_raddr),
		.rule_rdata  (rule_rdata),
		.tape_we     (tape_we),
		.tape_waddr  (tape_waddr),
		.tape_wdata  (tape_wdata),
		.tape_re     (tape_re),
		.tape_raddr  (tape_raddr),
		.tape_rdata  (tape_rdata),
		.res         (res)
	);

	tms_ram #(
		.WIDTH ($bits(rule_t)),
		.DEPTH (2 * STATE_COUNT)
	) u_rule_ram (
		.clk   (clk),
		.we    (rule_we),
		.waddr (rule_waddr),
		.wdata (rule_wdata),
		.re    (rule_re),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);

	tms_ram #(
		.WIDTH (1),
		.DEPTH (TAPE_CELLS)
	) u_tape_ram (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.re    (tape_re),
		.raddr (tape_raddr),
		.rdata (tape_rdata)
	);

	// The result fields are held in one register inside the core and change
	// only when a new item finishes.
	assign machine_state = res.machine_state;
	assign head_cell     = res.head_cell;
	assign symbol_out    = res.symbol_out;
	assign halted        = res.halted;
	assign status        = res.status;
	assign steps_done    = res.steps_done;

endmodule

`default_nettype wire

FILE: sv/tms_port_check.sv
// ----------------------------------------------------------------------------
// Turing machine stepper port checker
// Concurrent checks on the handshake and result ports of the stepper.
// ----------------------------------------------------------------------------
`default_nettype none

`include "turing_machine_stepper_top_defines.svh"

module tms_port_check (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic       halted,
	input wire logic [1:0] status
);

	import tms_pkg::*;

	// A taken item either answers at once or keeps the block busy.
	`TMS_ASSERT(a_accept_answered, start && !busy |=> done || busy, "item taken but neither done nor busy")

	// A result only follows a taken item or a busy cycle.
	`TMS_ASSERT(a_done_has_cause, done |-> $past(busy) || $past(start), "result without an item")

	// A step refused for being halted must report a halted machine.
	`TMS_NEVER(a_halt_status, done && status == STATUS_HALTED && !halted, "halted status while not halted")

endmodule

bind turing_machine_stepper_top tms_port_check u_port_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.halted (halted),
	.status (status)
);

`default_nettype wire

FILE: sim/turing_machine_stepper_checker.sv
// ----------------------------------------------------------------------------
// Turing machine stepper checker
// Follows every item and configuration write that the stepper takes, keeps its
// own copy of the machine, and compares each result strobe with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module turing_machine_stepper_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        done,
	input  logic [2:0]  action,
	input  logic [6:0]  rule_state,
	input  logic        rule_symbol,
	input  logic        rule_write,
	input  logic [6:0]  rule_next,
	input  logic [1:0]  rule_move,
	input  logic [5:0]  cell_index,
	input  logic        cell_symbol,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic [6:0]  machine_state,
	input  logic [5:0]  head_cell,
	input  logic        symbol_out,
	input  logic        halted,
	input  logic [1:0]  status,
	input  logic [31:0] steps_done,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import tms_pkg::*;

	localparam int TAPE_CELLS   = 64;
	localparam int STATE_COUNT  = 128;
	localparam int REPORT_LIMIT = 10;

	rule_t                 rule_mem [2*STATE_COUNT];
	logic [TAPE_CELLS-1:0] tape;
	logic [6:0]            cur_state;
	logic [5:0]            head;
	logic                  halt_flag;
	logic [31:0]           step_count;
	logic [6:0]            start_state_reg;
	logic [5:0]            start_head_reg;
	logic [6:0]            halt_state_reg;

	res_t due_results [$];
	res_t seen;
	res_t want;

	// Applies the item on the input ports to the machine copy and returns the
	// result it should produce.
	function automatic res_t advance_machine();
		res_t       r;
		rule_t      entry;
		logic [5:0] nh;
		logic [1:0] st;
		logic       is_read;
		logic       rd_bit;
		st      = STATUS_OK;
		is_read = 1'b0;
		rd_bit  = 1'b0;
		case (action)
			ACT_LOAD: begin
				entry.valid = 1'b1;
				entry.wr    = rule_write;
				entry.nxt   = rule_next;
				entry.move  = (rule_move == MOVE_BAD) ? MOVE_STAY : rule_move;
				rule_mem[{rule_state, rule_symbol}] = entry;
			end
			ACT_WRITE: tape[cell_index] = cell_symbol;
			ACT_READ: begin
				is_read = 1'b1;
				rd_bit  = tape[cell_index];
			end
			ACT_RESTART: begin
				cur_state  = start_state_reg;
				head       = (start_head_reg < TAPE_CELLS) ? start_head_reg : 6'(TAPE_CELLS - 1);
				halt_flag  = (start_state_reg == halt_state_reg);
				step_count = '0;
			end
			ACT_STEP: begin
				entry = rule_mem[{cur_state, tape[head]}];
				nh    = head;
				if (halt_flag) begin
					st = STATUS_HALTED;
				end else if (!entry.valid) begin
					st = STATUS_NORULE;
				end else if ((entry.move == MOVE_RIGHT && head == TAPE_CELLS - 1) ||
						(entry.move == MOVE_LEFT && head == 0)) begin
					st = STATUS_BOUNDS;
				end else begin
					if (entry.move == MOVE_RIGHT)
						nh = head + 6'd1;
					else if (entry.move == MOVE_LEFT)
						nh = head - 6'd1;
					tape[head] = entry.wr;
					head       = nh;
					cur_state  = entry.nxt;
					halt_flag  = (entry.nxt == halt_state_reg);
					if (step_count != '1)
						step_count++;
				end
			end
			default: ;
		endcase
		r.machine_state = cur_state;
		r.head_cell     = head;
		r.symbol_out    = is_read ? rd_bit : tape[head];
		r.halted        = halt_flag;
		r.status        = st;
		r.steps_done    = step_count;
		return r;
	endfunction

	function automatic string show(res_t v);
		return $sformatf("state=%0d head=%0d sym=%0d halted=%0d status=%0d steps=%0d",
			v.machine_state, v.head_cell, v.symbol_out, v.halted, v.status, v.steps_done);
	endfunction

	// Results are compared before the item taken at the same edge is predicted,
	// since a result always belongs to an earlier item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (rule_mem[i])
				rule_mem[i] = '0;
			tape            = '0;
			cur_state       = '0;
			head            = 6'd1;
			halt_flag       = 1'b0;
			step_count      = '0;
			start_state_reg = START_STATE_RESET;
			start_head_reg  = START_HEAD_RESET;
			halt_state_reg  = HALT_STATE_RESET;
			due_results.delete();
			fail_count      = 0;
			pending_count   = 0;
		end else begin
			if (done) begin
				seen = '{machine_state, head_cell, symbol_out, halted, status, steps_done};
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: result with no item outstanding: %s", $time, show(seen));
				end else begin
					want = due_results.pop_front();
					if (seen.machine_state !== want.machine_state ||
							seen.head_cell !== want.head_cell ||
							seen.symbol_out !== want.symbol_out ||
							seen.halted !== want.halted ||
							seen.status !== want.status ||
							seen.steps_done !== want.steps_done) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT)
							$display("%0t: mismatch\n  expected %s\n  actual   %s",
								$time, show(want), show(seen));
					end
				end
			end
			if (start && !busy)
				due_results.push_back(advance_machine());
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_STATE: start_state_reg = cfg_data;
					CFG_START_HEAD:  start_head_reg  = cfg_data[5:0];
					CFG_HALT_STATE:  halt_state_reg  = cfg_data;
					default: ;
				endcase
			end
			pending_count = due_results.size();
		end
	end

endmodule

FILE: sim/turing_machine_stepper_top_test.sv
// ----------------------------------------------------------------------------
// Turing machine stepper testbench
// Drives rule loads, tape accesses, restarts and steps into the stepper, first
// a directed walk through the corner cases and then randomly built machines
// that are run for many steps, while a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------
module turing_machine_stepper_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tms_pkg::*;

	// The one configuration index that the block has no register for.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Roughly how many items to send before the stimulus stops.
	localparam int TARGET_ITEMS = 1800;

	// Longest run of cycles in which neither an item nor a result is taken.
	// The clearing pass after reset, the sender's gaps and a step all end well
	// within this, so it is far beyond any correct run.
	localparam int QUIET_LIMIT = 2000;

	// All input fields of one item, in one bundle for the stimulus code.
	typedef struct packed {
		logic [2:0] action;
		logic [6:0] rstate;
		logic       rsym;
		logic       rwrite;
		logic [6:0] rnext;
		logic [1:0] rmove;
		logic [5:0] cidx;
		logic       csym;
	} item_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              done;
	logic [2:0]        action;
	logic [6:0]        rule_state;
	logic              rule_symbol;
	logic              rule_write;
	logic [6:0]        rule_next;
	logic signed [1:0] rule_move;
	logic [5:0]        cell_index;
	logic              cell_symbol;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [6:0]        cfg_data;
	logic [6:0]        machine_state;
	logic [5:0]        head_cell;
	logic              symbol_out;
	logic              halted;
	logic [1:0]        status;
	logic [31:0]       steps_done;
	int                fail_count;
	int                pending_count;

	// Sender pacing: items go out in bursts separated by idle gaps, except in
	// steady stretches where start stays high back to back.
	int   burst_left;
	bit   steady;
	int   items_sent;
	int   quiet_cycles;

	// The machine that the current random phase is built around: the states
	// its rules use and the state that halts it.
	logic [6:0] prog_states [12];
	int         prog_count;
	logic [6:0] cur_halt;

	turing_machine_stepper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.action        (action),
		.rule_state    (rule_state),
		.rule_symbol   (rule_symbol),
		.rule_write    (rule_write),
		.rule_next     (rule_next),
		.rule_move     (rule_move),
		.cell_index    (cell_index),
		.cell_symbol   (cell_symbol),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.machine_state (machine_state),
		.head_cell     (head_cell),
		.symbol_out    (symbol_out),
		.halted        (halted),
		.status        (status),
		.steps_done    (steps_done)
	);

	turing_machine_stepper_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.done          (done),
		.action        (action),
		.rule_state    (rule_state),
		.rule_symbol   (rule_symbol),
		.rule_write    (rule_write),
		.rule_next     (rule_next),
		.rule_move     (rule_move),
		.cell_index    (cell_index),
		.cell_symbol   (cell_symbol),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.machine_state (machine_state),
		.head_cell     (head_cell),
		.symbol_out    (symbol_out),
		.halted        (halted),
		.status        (status),
		.steps_done    (steps_done),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The watchdog restarts its count whenever an item or a result is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Every field random, so that fields an action does not use still toggle.
	function automatic item_t random_item();
		item_t c;
		c.action = 3'($urandom_range(0, 7));
		c.rstate = 7'($urandom);
		c.rsym   = 1'($urandom);
		c.rwrite = 1'($urandom);
		c.rnext  = 7'($urandom);
		c.rmove  = 2'($urandom);
		c.cidx   = 6'($urandom);
		c.csym   = 1'($urandom);
		return c;
	endfunction

	function automatic item_t bare_item(logic [2:0] act);
		item_t c;
		c = random_item();
		c.action = act;
		return c;
	endfunction

	function automatic item_t cell_item(logic [2:0] act, logic [5:0] idx, logic sym);
		item_t c;
		c = bare_item(act);
		c.cidx = idx;
		c.csym = sym;
		return c;
	endfunction

	function automatic item_t rule_item(logic [6:0] st, logic sym, logic wr,
			logic [6:0] nxt, logic [1:0] mv);
		item_t c;
		c = bare_item(ACT_LOAD);
		c.rstate = st;
		c.rsym   = sym;
		c.rwrite = wr;
		c.rnext  = nxt;
		c.rmove  = mv;
		return c;
	endfunction

	// A rule for the current machine: it mostly leads to one of the machine's
	// own states and now and then into the halt state. The move is any of the
	// four patterns, the unused one included.
	function automatic item_t rule_for(logic [6:0] st, logic sym);
		logic [6:0] nxt;
		nxt = ($urandom_range(0, 9) == 0) ? cur_halt
			: prog_states[$urandom_range(0, prog_count - 1)];
		return rule_item(st, sym, 1'($urandom), nxt, 2'($urandom_range(0, 3)));
	endfunction

	// Sends one item and returns at the edge where the block took it. Start
	// is left high so that the next item of a burst follows without a gap.
	task automatic issue(item_t c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (!steady) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		start       <= 1'b1;
		action      <= c.action;
		rule_state  <= c.rstate;
		rule_symbol <= c.rsym;
		rule_write  <= c.rwrite;
		rule_next   <= c.rnext;
		rule_move   <= c.rmove;
		cell_index  <= c.cidx;
		cell_symbol <= c.csym;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Holds the sender back until every result has come and the block is
	// idle. The checker's count is read at the falling edge, clear of the
	// rising edge where it changes.
	task automatic drain_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_count != 0 || busy);
		@(posedge clk);
	endtask

	// Writes all three registers on consecutive edges. Sometimes the index
	// with no register behind it is written too, which must change nothing.
	task automatic program_regs(logic [6:0] ss, logic [5:0] sh, logic [6:0] hs);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_START_STATE;
		cfg_data  <= ss;
		@(posedge clk);
		cfg_index <= CFG_START_HEAD;
		cfg_data  <= {1'($urandom), sh};
		@(posedge clk);
		cfg_index <= CFG_HALT_STATE;
		cfg_data  <= hs;
		@(posedge clk);
		if ($urandom_range(0, 1) == 1) begin
			cfg_index <= CFG_UNUSED;
			cfg_data  <= 7'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int         r;
		int         k;
		int         i;
		int         s;
		int         pick;
		int         round_len;
		logic [6:0] ss;
		logic [6:0] hs;
		logic [5:0] sh;

		// Every input is known from time zero on.
		arst_n       = 1'b0;
		start        = 1'b0;
		action       = ACT_LOAD;
		rule_state   = '0;
		rule_symbol  = 1'b0;
		rule_write   = 1'b0;
		rule_next    = '0;
		rule_move    = MOVE_STAY;
		cell_index   = '0;
		cell_symbol  = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = CFG_START_STATE;
		cfg_data     = '0;
		burst_left   = 0;
		steady       = 1'b0;
		items_sent   = 0;
		quiet_cycles = 0;
		prog_count   = 1;
		cur_halt     = HALT_STATE_RESET;
		foreach (prog_states[j])
			prog_states[j] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The block sweeps both memories clear after reset and shows busy
		// until it is done.
		@(posedge clk);
		while (busy)
			@(posedge clk);

		// Directed walk with the reset configuration: start state 0, head on
		// cell 1, halt state 104. A step with the rule memory still empty has
		// no rule to follow.
		issue(bare_item(ACT_STEP));

		// The last cell is read blank, both tape ends are marked and the last cell is read back.
		issue(cell_item(ACT_READ, 6'd63, 1'b0));
		issue(cell_item(ACT_WRITE, 6'd63, 1'b1));
		issue(cell_item(ACT_WRITE, 6'd0, 1'b1));
		issue(cell_item(ACT_READ, 6'd63, 1'b0));

		// A rule that is loaded again is replaced; the second one carries the
		// unused move pattern, which must act as a stay.
		issue(rule_item(7'd0, 1'b0, 1'b1, 7'd127, MOVE_RIGHT));
		issue(rule_item(7'd0, 1'b0, 1'b0, 7'd3, MOVE_BAD));
		issue(bare_item(ACT_STEP));

		// Step left onto cell 0 into the highest state, then try to move left
		// off the tape, which must leave everything as it was.
		issue(rule_item(7'd3, 1'b0, 1'b1, 7'd127, MOVE_LEFT));
		issue(bare_item(ACT_STEP));
		issue(rule_item(7'd127, 1'b1, 1'b1, 7'd127, MOVE_LEFT));
		issue(bare_item(ACT_STEP));

		// Enter the halt state, then step once more while halted.
		issue(rule_item(7'd127, 1'b1, 1'b0, HALT_STATE_RESET, MOVE_STAY));
		issue(bare_item(ACT_STEP));
		issue(bare_item(ACT_STEP));

		// The three action codes beyond step do nothing.
		for (k = 1; k <= 3; k++)
			issue(bare_item(ACT_STEP + 3'(k)));
		issue(bare_item(ACT_RESTART));

		// A restart into the halt state comes out halted.
		drain_results();
		program_regs(HALT_STATE_RESET, 6'd63, HALT_STATE_RESET);
		issue(bare_item(ACT_RESTART));
		issue(bare_item(ACT_STEP));

		// From the last cell a move to the right would leave the tape.
		drain_results();
		program_regs(7'd5, 6'd63, 7'd127);
		issue(rule_item(7'd5, 1'b1, 1'b0, 7'd0, MOVE_RIGHT));
		issue(bare_item(ACT_RESTART));
		issue(bare_item(ACT_STEP));

		// Random phases. Each one sets the registers, builds a small machine
		// around the start state, marks some cells and then runs it, mostly by
		// stepping, with restarts, rule reloads, tape accesses and noise mixed
		// in. Rules of earlier phases stay in the memory.
		r = 0;
		while (items_sent < TARGET_ITEMS) begin
			drain_results();
			case (r % 4)
				0: begin
					ss = 7'd0;
					sh = 6'd0;
					hs = 7'd127;
				end
				1: begin
					ss = 7'd127;
					sh = 6'd63;
					hs = 7'd0;
				end
				default: begin
					ss = 7'($urandom);
					sh = 6'($urandom);
					hs = 7'($urandom);
				end
			endcase
			program_regs(ss, sh, hs);
			cur_halt       = hs;
			prog_count     = $urandom_range(3, 12);
			prog_states[0] = ss;
			for (i = 1; i < prog_count; i++)
				prog_states[i] = 7'($urandom);
			steady = ($urandom_range(0, 3) == 0);

			// Most (state, symbol) pairs get a rule; the gaps give steps with
			// no rule to follow.
			for (i = 0; i < prog_count; i++)
				for (s = 0; s < 2; s++)
					if ($urandom_range(0, 9) != 0)
						issue(rule_for(prog_states[i], 1'(s)));
			repeat ($urandom_range(4, 16))
				issue(cell_item(ACT_WRITE, 6'($urandom), 1'($urandom)));
			issue(bare_item(ACT_RESTART));

			round_len = $urandom_range(120, 220);
			for (k = 0; k < round_len; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 78)
					issue(bare_item(ACT_STEP));
				else if (pick < 84)
					issue(bare_item(ACT_RESTART));
				else if (pick < 89)
					issue(rule_for(prog_states[$urandom_range(0, prog_count - 1)],
						1'($urandom)));
				else if (pick < 93)
					issue(cell_item(ACT_WRITE, 6'($urandom), 1'($urandom)));
				else if (pick < 96)
					issue(bare_item(ACT_READ));
				else if (pick < 98)
					issue(bare_item(ACT_STEP + 3'($urandom_range(1, 3))));
				else
					issue(random_item());
				// Now and then the sender waits for every result to come.
				if ($urandom_range(0, 49) == 0)
					drain_results();
				// Steady stretches end at random so that pacing changes within
				// a phase too.
				if ($urandom_range(0, 63) == 0)
					steady = !steady;
			end
			r++;
		end

		// Let the last results arrive, then give the block a few more cycles
		// in which it must stay quiet.
		drain_results();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
